[design/abc_ntp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abc_ntp_pkg
// shared types, character codes and helpers for the abc note token parser
// ----------------------------------------------------------------------------
package abc_ntp_pkg;

    typedef logic [7:0]         t_char;
    typedef logic signed [11:0] t_pitch;
    typedef logic [3:0]         t_len_code;
    typedef logic [7:0]         t_cfg_data;
    typedef logic [2:0]         t_len_count;
    typedef logic [9:0]         t_len_value;
    typedef logic [1:0]         t_line_pos;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_REST_CODE     = 1'b0,
        CFG_NO_PITCH_CODE = 1'b1
    } t_cfg_index;

    // character categories, in their ordering
    typedef enum logic [2:0] {
        KIND_NONE   = 3'd0,
        KIND_ACC    = 3'd1,
        KIND_PITCH  = 3'd2,
        KIND_OCTAVE = 3'd3,
        KIND_LENGTH = 3'd4
    } t_kind;

    localparam t_len_count LENGTH_CHARS_KEPT = 3'd7;
    localparam t_len_value LEN_VALUE_MAX     = 10'd1023;

    localparam t_cfg_data REST_CODE_RESET     = 8'd255;
    localparam t_cfg_data NO_PITCH_CODE_RESET = 8'd254;

    localparam t_char CH_NEWLINE = 8'd10;
    localparam t_char CH_K       = 8'h4B;
    localparam t_char CH_COLON   = 8'h3A;
    localparam t_char CH_PERCENT = 8'h25;
    localparam t_char CH_SLASH   = 8'h2F;
    localparam t_char CH_CARET   = 8'h5E;
    localparam t_char CH_EQUALS  = 8'h3D;
    localparam t_char CH_UNDER   = 8'h5F;
    localparam t_char CH_QUOTE   = 8'h27;
    localparam t_char CH_COMMA   = 8'h2C;
    localparam t_char CH_ZERO    = 8'h30;
    localparam t_char CH_NINE    = 8'h39;

    localparam t_len_code LEN_CODE_WHOLE   = 4'd5;
    localparam t_len_code LEN_CODE_HALF    = 4'd4;
    localparam t_len_code LEN_CODE_INVALID = 4'd10;

    // length code from the gathered length characters
    function automatic t_len_code length_code(
        input t_len_count count,
        input logic       first_slash,
        input t_len_value value
    );
        t_len_code code;
        code = LEN_CODE_INVALID;
        if (count == '0) begin
            code = LEN_CODE_WHOLE;
        end else if (first_slash) begin
            if (count == 3'd1) begin
                code = LEN_CODE_HALF;
            end else begin
                case (value)
                    10'd32:  code = 4'd0;
                    10'd16:  code = 4'd1;
                    10'd8:   code = 4'd2;
                    10'd4:   code = 4'd3;
                    10'd2:   code = 4'd4;
                    10'd1:   code = 4'd5;
                    default: code = LEN_CODE_INVALID;
                endcase
            end
        end else begin
            case (value)
                10'd1:   code = 4'd5;
                10'd2:   code = 4'd6;
                10'd4:   code = 4'd7;
                10'd8:   code = 4'd8;
                10'd16:  code = 4'd9;
                default: code = LEN_CODE_INVALID;
            endcase
        end
        return code;
    endfunction

    // saturating step of a signed 8-bit sum by -1, 0 or +1
    function automatic logic signed [7:0] sat_step(
        input logic signed [7:0] acc,
        input logic              up,
        input logic              down
    );
        logic signed [7:0] res;
        res = acc;
        if (up && acc != 8'sd127) begin
            res = acc + 8'sd1;
        end else if (down && acc != -8'sd128) begin
            res = acc - 8'sd1;
        end
        return res;
    endfunction

endpackage

[design/abc_ntp_char_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abc_ntp_char_if
// character stream channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface abc_ntp_char_if;
    import abc_ntp_pkg::*;

    logic  valid;
    logic  ready;
    t_char char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

[design/abc_ntp_note_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abc_ntp_note_if
// note result channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface abc_ntp_note_if;
    import abc_ntp_pkg::*;

    logic      valid;
    logic      ready;
    t_pitch    note_pitch;
    t_len_code note_length_code;

    modport source (output valid, output note_pitch, output note_length_code, input ready);
    modport sink   (input valid, input note_pitch, input note_length_code, output ready);
endinterface

[design/abc_note_token_parser_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abc_note_token_parser_core
// turns abc music text, one character per transaction, into notes
// ----------------------------------------------------------------------------
//  channel   | direction | payload                          | handshake
//  ----------+-----------+----------------------------------+-------------
//  i_char    | in        | char_code [7:0]                  | valid/ready
//  o_note    | out       | note_pitch [11:0] s, length [3:0] | valid/ready
//  i_cfg_*   | in        | index [0:0], data [7:0]          | write enable
//
//  one character is taken per cycle unless a stalled sink holds a note;
//  the parse state is updated in the same cycle and a finished note
//  lands in the output register; a new character is taken whenever the
//  output register is empty or is being emptied in that cycle
//  synchronous active-low reset returns the parser to the header search,
//  rest code 255, no-pitch code 254
// ----------------------------------------------------------------------------
module abc_note_token_parser_core (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    abc_ntp_char_if.sink            i_char,
    abc_ntp_note_if.source          o_note,
    input  logic                    i_cfg_we,
    input  abc_ntp_pkg::t_cfg_index i_cfg_index,
    input  abc_ntp_pkg::t_cfg_data  i_cfg_data
);
    import abc_ntp_pkg::*;

    // configuration
    t_cfg_data r_rest_code;
    t_cfg_data r_no_pitch_code;

    // line and header tracking
    logic      r_header_seen,  n_header_seen;
    t_line_pos r_line_pos,     n_line_pos;
    logic      r_first_was_k,  n_first_was_k;
    logic      r_skip_line,    n_skip_line;
    t_kind     r_last_kind,    n_last_kind;

    // note being gathered
    logic [7:0]        r_note_base,   n_note_base;
    logic signed [7:0] r_note_acc,    n_note_acc;
    logic signed [7:0] r_note_oct,    n_note_oct;
    logic              r_note_present, n_note_present;
    t_len_count        r_len_count,   n_len_count;
    logic              r_len_slash,   n_len_slash;
    t_len_value        r_len_value,   n_len_value;
    logic              r_len_done,    n_len_done;

    // output register
    logic      r_out_valid;
    t_pitch    r_out_pitch;
    t_len_code r_out_len;

    logic       accept;
    logic       emit;
    t_char      c;
    t_kind      kind;
    logic       delta_up;
    logic       delta_down;
    logic [7:0] pitch_base;
    logic       is_digit;
    logic       start_new;
    logic [13:0] len_next;
    t_pitch     acc_x;
    t_pitch     oct_x;
    t_pitch     note_pitch;

    assign i_char.ready = !r_out_valid || o_note.ready;
    assign accept       = i_char.valid && i_char.ready;
    assign c            = i_char.char_code;

    assign o_note.valid            = r_out_valid;
    assign o_note.note_pitch       = r_out_pitch;
    assign o_note.note_length_code = r_out_len;

    // pitch of the gathered note: base + accidentals + 12 * octaves
    assign acc_x      = {{4{r_note_acc[7]}}, r_note_acc};
    assign oct_x      = {{4{r_note_oct[7]}}, r_note_oct};
    assign note_pitch = {4'b0, r_note_base} + acc_x + (oct_x <<< 3) + (oct_x <<< 2);

    // value * 10 plus new digit, saturated later
    assign len_next = {1'b0, r_len_value, 3'b0} + {3'b0, r_len_value, 1'b0}
                    + {10'b0, 4'(c - CH_ZERO)};

    // character classification
    always_comb begin
        kind       = KIND_NONE;
        delta_up   = 1'b0;
        delta_down = 1'b0;
        pitch_base = '0;
        is_digit   = (c >= CH_ZERO) && (c <= CH_NINE);
        case (c)
            CH_CARET:  begin kind = KIND_ACC; delta_up = 1'b1; end
            CH_EQUALS: kind = KIND_ACC;
            CH_UNDER:  begin kind = KIND_ACC; delta_down = 1'b1; end
            "C": begin kind = KIND_PITCH; pitch_base = 8'd0;  end
            "D": begin kind = KIND_PITCH; pitch_base = 8'd2;  end
            "E": begin kind = KIND_PITCH; pitch_base = 8'd4;  end
            "F": begin kind = KIND_PITCH; pitch_base = 8'd5;  end
            "G": begin kind = KIND_PITCH; pitch_base = 8'd7;  end
            "A": begin kind = KIND_PITCH; pitch_base = 8'd9;  end
            "B": begin kind = KIND_PITCH; pitch_base = 8'd11; end
            "c": begin kind = KIND_PITCH; pitch_base = 8'd12; end
            "d": begin kind = KIND_PITCH; pitch_base = 8'd14; end
            "e": begin kind = KIND_PITCH; pitch_base = 8'd16; end
            "f": begin kind = KIND_PITCH; pitch_base = 8'd17; end
            "g": begin kind = KIND_PITCH; pitch_base = 8'd19; end
            "a": begin kind = KIND_PITCH; pitch_base = 8'd21; end
            "b": begin kind = KIND_PITCH; pitch_base = 8'd23; end
            "z", "Z", "x": begin kind = KIND_PITCH; pitch_base = r_rest_code; end
            CH_QUOTE:  begin kind = KIND_OCTAVE; delta_up = 1'b1; end
            CH_COMMA:  begin kind = KIND_OCTAVE; delta_down = 1'b1; end
            default: begin
                if (is_digit || c == CH_SLASH) begin
                    kind = KIND_LENGTH;
                end
            end
        endcase
    end

    // category falls back, or a second pitch: the note so far is finished
    assign start_new = (kind != KIND_PITCH && kind < r_last_kind)
                    || (kind == KIND_PITCH && kind <= r_last_kind);

    // next parse state
    always_comb begin
        n_header_seen  = r_header_seen;
        n_line_pos     = r_line_pos;
        n_first_was_k  = r_first_was_k;
        n_skip_line    = r_skip_line;
        n_last_kind    = r_last_kind;
        n_note_base    = r_note_base;
        n_note_acc     = r_note_acc;
        n_note_oct     = r_note_oct;
        n_note_present = r_note_present;
        n_len_count    = r_len_count;
        n_len_slash    = r_len_slash;
        n_len_value    = r_len_value;
        n_len_done     = r_len_done;
        emit           = 1'b0;

        if (c == CH_NEWLINE) begin
            emit           = r_header_seen && !r_skip_line && r_note_present;
            n_note_base    = r_no_pitch_code;
            n_note_acc     = '0;
            n_note_oct     = '0;
            n_note_present = 1'b0;
            n_len_count    = '0;
            n_len_slash    = 1'b0;
            n_len_value    = '0;
            n_len_done     = 1'b0;
            n_last_kind    = KIND_NONE;
            n_skip_line    = 1'b0;
            n_line_pos     = '0;
            n_first_was_k  = 1'b0;
        end else begin
            if (r_line_pos != 2'd2) begin
                n_line_pos = r_line_pos + 2'd1;
            end
            if (!r_header_seen) begin
                // waiting for a line starting with K:
                if (r_line_pos == 2'd0) begin
                    n_first_was_k = (c == CH_K);
                end else if (r_line_pos == 2'd1 && r_first_was_k && c == CH_COLON) begin
                    n_header_seen = 1'b1;
                    n_skip_line   = 1'b1;
                end
            end else if (!r_skip_line) begin
                if (c == CH_PERCENT) begin
                    // comment: flush and ignore the rest of the line
                    emit           = r_note_present;
                    n_note_base    = r_no_pitch_code;
                    n_note_acc     = '0;
                    n_note_oct     = '0;
                    n_note_present = 1'b0;
                    n_len_count    = '0;
                    n_len_slash    = 1'b0;
                    n_len_value    = '0;
                    n_len_done     = 1'b0;
                    n_last_kind    = KIND_NONE;
                    n_skip_line    = 1'b1;
                end else if (kind != KIND_NONE) begin
                    if (start_new) begin
                        emit        = r_note_present;
                        n_note_base = r_no_pitch_code;
                        n_note_acc  = '0;
                        n_note_oct  = '0;
                        n_len_count = '0;
                        n_len_slash = 1'b0;
                        n_len_value = '0;
                        n_len_done  = 1'b0;
                    end
                    unique case (kind)
                        KIND_ACC:    n_note_acc  = sat_step(n_note_acc, delta_up, delta_down);
                        KIND_PITCH:  n_note_base = pitch_base;
                        KIND_OCTAVE: n_note_oct  = sat_step(n_note_oct, delta_up, delta_down);
                        default: begin
                            // length character, only the first few are kept
                            if (n_len_count < LENGTH_CHARS_KEPT) begin
                                if (c == CH_SLASH) begin
                                    if (n_len_count == '0) begin
                                        n_len_slash = 1'b1;
                                    end else begin
                                        n_len_done = 1'b1;
                                    end
                                end else if (!n_len_done) begin
                                    // after a fresh note the value is zero, so
                                    // the digit alone is the new value
                                    if (start_new) begin
                                        n_len_value = 10'(c - CH_ZERO);
                                    end else if (len_next > 14'(LEN_VALUE_MAX)) begin
                                        n_len_value = LEN_VALUE_MAX;
                                    end else begin
                                        n_len_value = len_next[9:0];
                                    end
                                end
                                n_len_count = n_len_count + 3'd1;
                            end
                        end
                    endcase
                    n_note_present = 1'b1;
                    n_last_kind    = kind;
                end
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rest_code     <= REST_CODE_RESET;
            r_no_pitch_code <= NO_PITCH_CODE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_REST_CODE:     r_rest_code     <= i_cfg_data;
                CFG_NO_PITCH_CODE: r_no_pitch_code <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_seen  <= 1'b0;
            r_line_pos     <= '0;
            r_first_was_k  <= 1'b0;
            r_skip_line    <= 1'b0;
            r_last_kind    <= KIND_NONE;
            r_note_base    <= NO_PITCH_CODE_RESET;
            r_note_acc     <= '0;
            r_note_oct     <= '0;
            r_note_present <= 1'b0;
            r_len_count    <= '0;
            r_len_slash    <= 1'b0;
            r_len_value    <= '0;
            r_len_done     <= 1'b0;
        end else if (accept) begin
            r_header_seen  <= n_header_seen;
            r_line_pos     <= n_line_pos;
            r_first_was_k  <= n_first_was_k;
            r_skip_line    <= n_skip_line;
            r_last_kind    <= n_last_kind;
            r_note_base    <= n_note_base;
            r_note_acc     <= n_note_acc;
            r_note_oct     <= n_note_oct;
            r_note_present <= n_note_present;
            r_len_count    <= n_len_count;
            r_len_slash    <= n_len_slash;
            r_len_value    <= n_len_value;
            r_len_done     <= n_len_done;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && emit) begin
            r_out_valid <= 1'b1;
        end else if (o_note.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_out_pitch <= note_pitch;
            r_out_len   <= length_code(r_len_count, r_len_slash, r_len_value);
        end
    end

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the abc note token parser core: a queue-fed
// character driver with bursts and gaps, a note sink with its own stall
// pattern and one long hold-off, and a bit-exact parse predictor whose
// expected notes are compared field by field with every note transaction
// ----------------------------------------------------------------------------
module tb_top;
    import abc_ntp_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transaction
    localparam int HOLD_CYCLES    = 300;   // long sink hold-off, block must fill
    localparam int IDLE_SETTLE    = 4;     // cycles after the last note before a write
    localparam int END_SETTLE     = 10;    // cycles after the last note at the end
    localparam int PHASE_CHARS    = 40;    // random characters per phase

    typedef struct packed {
        t_pitch    pitch;
        t_len_code len_code;
    } t_note;

    // sink stall patterns
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_RHYTHM
    } t_rx_mode;

    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we    = 1'b0;
    t_cfg_index i_cfg_index = CFG_REST_CODE;
    t_cfg_data  i_cfg_data  = '0;

    abc_ntp_char_if char_ch ();
    abc_ntp_note_if note_ch ();

    abc_note_token_parser_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_char      (char_ch),
        .o_note      (note_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // parse predictor: its own copy of the configuration and the parse state
    // ------------------------------------------------------------------------
    t_cfg_data         rest_code_q;
    t_cfg_data         no_pitch_q;
    logic              header_seen_q;
    t_line_pos         line_pos_q;
    logic              first_k_q;
    logic              skip_line_q;
    t_kind             last_kind_q;
    logic [7:0]        note_base_q;
    logic signed [7:0] note_acc_q;
    logic signed [7:0] note_oct_q;
    logic              note_present_q;
    t_len_count        len_cnt_q;
    logic              len_slash_q;
    t_len_value        len_val_q;
    logic              len_done_q;

    t_note note_expect[$];   // notes predicted but not yet seen on the output

    function automatic logic signed [7:0] clamp_add8(input logic signed [7:0] a,
                                                     input int d);
        int s;
        s = int'(a) + d;
        if (s > 127) s = 127;
        if (s < -128) s = -128;
        return s[7:0];
    endfunction

    // the length value must be a power of two; the slash form counts down
    // from a whole note, the plain form counts up
    function automatic t_len_code predict_len_code();
        t_len_code code;
        code = LEN_CODE_INVALID;
        if (len_cnt_q == '0) begin
            code = LEN_CODE_WHOLE;
        end else if (len_slash_q && len_cnt_q == 3'd1) begin
            code = LEN_CODE_HALF;
        end else begin
            for (int k = 0; k <= 5; k++) begin
                if (int'(len_val_q) == (1 << k)) begin
                    if (len_slash_q) begin
                        code = LEN_CODE_WHOLE - t_len_code'(k);
                    end else if (k <= 4) begin
                        code = LEN_CODE_WHOLE + t_len_code'(k);
                    end
                end
            end
        end
        return code;
    endfunction

    task automatic start_note();
        note_base_q    = no_pitch_q;
        note_acc_q     = '0;
        note_oct_q     = '0;
        note_present_q = 1'b0;
        len_cnt_q      = '0;
        len_slash_q    = 1'b0;
        len_val_q      = '0;
        len_done_q     = 1'b0;
    endtask

    // finished note goes to the expectations, then an empty note begins
    task automatic close_note();
        t_note n;
        int    p;
        if (note_present_q) begin
            p          = int'(note_base_q) + int'(note_acc_q) + 12 * int'(note_oct_q);
            n.pitch    = p[11:0];
            n.len_code = predict_len_code();
            note_expect.push_back(n);
        end
        start_note();
    endtask

    task automatic reset_parser_model();
        rest_code_q   = REST_CODE_RESET;
        no_pitch_q    = NO_PITCH_CODE_RESET;
        header_seen_q = 1'b0;
        line_pos_q    = '0;
        first_k_q     = 1'b0;
        skip_line_q   = 1'b0;
        last_kind_q   = KIND_NONE;
        start_note();
        note_expect.delete();
    endtask

    task automatic model_char(input t_char c);
        t_kind     kind;
        int        val;
        int        v;
        t_line_pos pos;
        kind = KIND_NONE;
        val  = 0;
        pos  = line_pos_q;

        // end of line flushes once the header is seen, unless the line is being skipped
        if (c == CH_NEWLINE) begin
            if (header_seen_q && !skip_line_q) close_note();
            start_note();
            last_kind_q = KIND_NONE;
            skip_line_q = 1'b0;
            line_pos_q  = '0;
            first_k_q   = 1'b0;
            return;
        end
        if (line_pos_q < 2'd2) line_pos_q = line_pos_q + 2'd1;

        // header search: K then colon as the first two characters
        if (!header_seen_q) begin
            if (pos == 2'd0) begin
                first_k_q = (c == CH_K);
            end else if (pos == 2'd1 && first_k_q && c == CH_COLON) begin
                header_seen_q = 1'b1;
                skip_line_q   = 1'b1;
            end
            return;
        end
        if (skip_line_q) return;

        // comment: flush, then ignore to the end of the line
        if (c == CH_PERCENT) begin
            close_note();
            last_kind_q = KIND_NONE;
            skip_line_q = 1'b1;
            return;
        end

        case (c)
            CH_CARET:  begin kind = KIND_ACC;    val = 1;  end
            CH_EQUALS: begin kind = KIND_ACC;    val = 0;  end
            CH_UNDER:  begin kind = KIND_ACC;    val = -1; end
            "C":       begin kind = KIND_PITCH;  val = 0;  end
            "D":       begin kind = KIND_PITCH;  val = 2;  end
            "E":       begin kind = KIND_PITCH;  val = 4;  end
            "F":       begin kind = KIND_PITCH;  val = 5;  end
            "G":       begin kind = KIND_PITCH;  val = 7;  end
            "A":       begin kind = KIND_PITCH;  val = 9;  end
            "B":       begin kind = KIND_PITCH;  val = 11; end
            "c":       begin kind = KIND_PITCH;  val = 12; end
            "d":       begin kind = KIND_PITCH;  val = 14; end
            "e":       begin kind = KIND_PITCH;  val = 16; end
            "f":       begin kind = KIND_PITCH;  val = 17; end
            "g":       begin kind = KIND_PITCH;  val = 19; end
            "a":       begin kind = KIND_PITCH;  val = 21; end
            "b":       begin kind = KIND_PITCH;  val = 23; end
            "z", "Z", "x": begin
                kind = KIND_PITCH;
                val  = int'(rest_code_q);
            end
            CH_QUOTE:  begin kind = KIND_OCTAVE; val = 1;  end
            CH_COMMA:  begin kind = KIND_OCTAVE; val = -1; end
            default: begin
                if ((c >= CH_ZERO && c <= CH_NINE) || c == CH_SLASH) kind = KIND_LENGTH;
            end
        endcase
        // unknown characters leave everything alone
        if (kind == KIND_NONE) return;

        // category falls back, or a second pitch: the gathered note is done
        if ((kind != KIND_PITCH && kind < last_kind_q) ||
            (kind == KIND_PITCH && kind <= last_kind_q)) begin
            close_note();
        end

        case (kind)
            KIND_ACC:    note_acc_q  = clamp_add8(note_acc_q, val);
            KIND_PITCH:  note_base_q = val[7:0];
            KIND_OCTAVE: note_oct_q  = clamp_add8(note_oct_q, val);
            default: begin
                // only the first few length characters are kept
                if (len_cnt_q < LENGTH_CHARS_KEPT) begin
                    if (c == CH_SLASH) begin
                        if (len_cnt_q == '0) len_slash_q = 1'b1;
                        else                 len_done_q  = 1'b1;
                    end else if (!len_done_q) begin
                        v = int'(len_val_q) * 10 + int'(c) - int'(CH_ZERO);
                        if (v > int'(LEN_VALUE_MAX)) v = int'(LEN_VALUE_MAX);
                        len_val_q = v[9:0];
                    end
                    len_cnt_q = len_cnt_q + 3'd1;
                end
            end
        endcase
        note_present_q = 1'b1;
        last_kind_q    = kind;
    endtask

    // ------------------------------------------------------------------------
    // shared bench state
    // ------------------------------------------------------------------------
    t_char char_q[$];          // characters waiting for the driver
    int    chars_pushed = 0;
    int    chars_taken  = 0;
    int    idle_cycles  = 0;
    int    fail_count   = 0;
    logic  char_taken   = 1'b0;   // char transaction at the last rising edge
    bit    hold_req     = 1'b0;
    bit    hold_done    = 1'b0;
    t_note want;

    // sender burst shaping
    int burst_left = 1;
    int gap_left   = 0;

    // sink pattern
    t_rx_mode rx_mode = RX_OPEN;
    int       rx_left = 0;
    int       rx_tick = 0;
    int       hold_left = 0;

    // ------------------------------------------------------------------------
    // character driver: holds an offered character until it is taken,
    // otherwise works through bursts and gaps
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            char_ch.valid <= 1'b0;
        end else if (!char_ch.valid || char_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                char_ch.valid <= 1'b0;
            end else if (char_q.size() > 0) begin
                char_ch.valid     <= 1'b1;
                char_ch.char_code <= char_q.pop_front();
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    // a quarter of the bursts run straight into the next one
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                char_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // note sink: one long hold-off on request, otherwise a rotating pattern
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            note_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            note_ch.ready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            note_ch.ready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                rx_left = $urandom_range(8, 60);
            end
            rx_left--;
            rx_tick++;
            case (rx_mode)
                RX_OPEN:   note_ch.ready <= 1'b1;
                RX_COIN:   note_ch.ready <= ($urandom_range(0, 1) == 1);
                RX_SPARSE: note_ch.ready <= ($urandom_range(0, 3) == 0);
                default:   note_ch.ready <= ((rx_tick % 4) != 3);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // monitor: config writes, note checks and the predictor, all at the
    // rising edge
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        char_taken <= char_ch.valid && char_ch.ready;
        if (!i_rst_n) begin
            reset_parser_model();
            idle_cycles = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_REST_CODE) rest_code_q = i_cfg_data;
                else                              no_pitch_q  = i_cfg_data;
            end

            if (note_ch.valid && note_ch.ready) begin
                if (note_expect.size() == 0) begin
                    $display("%0t: unexpected note, pitch %0d length code %0d",
                             $time, note_ch.note_pitch, note_ch.note_length_code);
                    fail_count++;
                end else begin
                    want = note_expect.pop_front();
                    if (note_ch.note_pitch !== want.pitch) begin
                        $display("%0t: note pitch expected %0d actual %0d",
                                 $time, want.pitch, note_ch.note_pitch);
                        fail_count++;
                    end
                    if (note_ch.note_length_code !== want.len_code) begin
                        $display("%0t: note length code expected %0d actual %0d",
                                 $time, want.len_code, note_ch.note_length_code);
                        fail_count++;
                    end
                end
            end

            // a note from this character can only show up after this edge
            if (char_ch.valid && char_ch.ready) begin
                model_char(char_ch.char_code);
                chars_taken++;
            end

            if ((char_ch.valid && char_ch.ready) || (note_ch.valid && note_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    // watchdog
    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    string acc_set   = "^=_";
    string pitch_set = "CDEFGABcdefgabzZx";
    string oct_set   = "',";
    string len_set   = "0123456789/";
    string len_forms[20] = '{"", "1", "2", "4", "8", "16", "/", "/2", "/4", "/8",
                             "/16", "/32", "//", "3", "1/2", "99999", "/64",
                             "/99999", "0", "/1"};

    task automatic push_char(input t_char c);
        char_q.push_back(c);
        chars_pushed++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_char(s[i]);
    endtask

    // one note-shaped token most of the time, otherwise noise or a comment
    task automatic push_token();
        int sel;
        int k;
        sel = $urandom_range(0, 99);
        if (sel < 10) begin
            push_char(t_char'($urandom_range(0, 255)));
        end else if (sel < 13) begin
            push_char(CH_PERCENT);
            repeat ($urandom_range(0, 4)) push_char(t_char'($urandom_range(32, 126)));
        end else begin
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 2)) push_char(acc_set[$urandom_range(0, 2)]);
            if ($urandom_range(0, 9) != 0)
                push_char(pitch_set[$urandom_range(0, pitch_set.len() - 1)]);
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 2)) push_char(oct_set[$urandom_range(0, 1)]);
            k = $urandom_range(0, 9);
            if (k < 6)
                push_text(len_forms[$urandom_range(0, $size(len_forms) - 1)]);
            else if (k < 8)
                repeat ($urandom_range(1, 9)) push_char(len_set[$urandom_range(0, 10)]);
            if ($urandom_range(0, 4) == 0) push_char(" ");
        end
    endtask

    task automatic run_random_phase(input int target);
        int start;
        int line_start;
        int line_goal;
        start = chars_pushed;
        while (chars_pushed - start < target) begin
            line_goal  = $urandom_range(3, 30);
            line_start = chars_pushed;
            while (chars_pushed - line_start < line_goal) push_token();
            push_char(CH_NEWLINE);
        end
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (chars_taken != chars_pushed || note_expect.size() != 0);
        repeat (IDLE_SETTLE) @(negedge i_clk);
    endtask

    task automatic write_cfg(input t_cfg_index idx, input t_cfg_data val);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    initial begin
        char_ch.valid     = 1'b0;
        char_ch.char_code = '0;
        note_ch.ready     = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // header search: K not first, then a real header whose tail is skipped
        push_text("xK:");
        push_char(CH_NEWLINE);
        push_text("K:A");
        push_char(CH_NEWLINE);
        // all accidentals and octave marks, an unknown byte, rests, second
        // pitch, length after rest, comment flush
        push_text("_^=G',/8");
        push_char(8'h00);
        push_text("zZ2%Q");
        push_char(CH_NEWLINE);
        // empty line flushes nothing
        push_char(CH_NEWLINE);
        // lone slash, top byte ignored, slash without a number
        push_text("c/");
        push_char(8'hFF);
        push_text("^//");
        push_char(CH_NEWLINE);
        run_random_phase(PHASE_CHARS);

        // lowest codes, with the sink holding off long enough to back up
        wait_idle();
        write_cfg(CFG_REST_CODE, 8'h00);
        write_cfg(CFG_NO_PITCH_CODE, 8'h00);
        hold_req = 1'b1;
        run_random_phase(PHASE_CHARS);

        // saturated sharps and octaves upwards on a top-code rest
        wait_idle();
        write_cfg(CFG_REST_CODE, 8'hFF);
        write_cfg(CFG_NO_PITCH_CODE, 8'h00);
        repeat (129) push_char(CH_CARET);
        push_char("z");
        repeat (129) push_char(CH_QUOTE);
        push_text("16");
        push_char(CH_NEWLINE);
        run_random_phase(PHASE_CHARS);

        wait_idle();
        write_cfg(CFG_REST_CODE, t_cfg_data'($urandom_range(0, 255)));
        write_cfg(CFG_NO_PITCH_CODE, t_cfg_data'($urandom_range(0, 255)));
        run_random_phase(PHASE_CHARS);

        // saturated flats and octaves downwards
        wait_idle();
        write_cfg(CFG_REST_CODE, 8'h00);
        write_cfg(CFG_NO_PITCH_CODE, 8'hFF);
        repeat (129) push_char(CH_UNDER);
        push_char("C");
        repeat (129) push_char(CH_COMMA);
        push_text("/32");
        push_char(CH_NEWLINE);
        run_random_phase(PHASE_CHARS);

        wait_idle();
        repeat (END_SETTLE) @(posedge i_clk);
        if (note_expect.size() != 0) begin
            $display("%0t: %0d expected notes never arrived", $time, note_expect.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
